FILE: sv/crcfr_pkg.sv
`timescale 1ns / 1ps

package crcfr_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 4;
	localparam int CRC_W     = 16;
	localparam int PAYLOAD_W = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

	// payload lengths announced by the two frame types
	localparam logic [LEN_W-1:0] SENSOR_LEN_FULL = 4'd8;
	localparam logic [LEN_W-1:0] SYNC_LEN_FULL   = 4'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_TYPE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_TYPE    = 2'd3;

	typedef enum logic [2:0] {
		STG_HUNT_FIRST  = 3'd0,
		STG_HUNT_SECOND = 3'd1,
		STG_TYPE        = 3'd2,
		STG_PAYLOAD     = 3'd3,
		STG_CRC         = 3'd4
	} parse_stage_t;

	// crc-16/ccitt, msb first, one byte
	function automatic logic [CRC_W-1:0] crc16_byte(
		input logic [CRC_W-1:0]  crc,
		input logic [BYTE_W-1:0] data
	);
		logic [CRC_W-1:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			if ((c & CRC_TOP) != '0)
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

endpackage

FILE: sv/crcfr_in_if.sv
`timescale 1ns / 1ps

interface crcfr_in_if;
	import crcfr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/crcfr_out_if.sv
`timescale 1ns / 1ps

interface crcfr_out_if;
	import crcfr_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [BYTE_W-1:0]    frame_type;
	logic [LEN_W-1:0]     payload_length;
	logic [PAYLOAD_W-1:0] payload_data;

	modport source (output valid, output frame_type, output payload_length,
		output payload_data, input ready);
	modport sink   (input valid, input frame_type, input payload_length,
		input payload_data, output ready);
endinterface

FILE: sv/crc_checked_frame_receiver.sv
`timescale 1ns / 1ps

// framed serial receiver with crc-16/ccitt check
// in_ch carries one received byte per beat. the parser hunts for the two
// start bytes, reads a type byte (sensor type: 8 payload bytes, sync type:
// 2 payload bytes, anything else restarts the hunt), collects the payload
// and then a little-endian crc computed over type and payload (init ffff).
// a good frame leaves as one beat on out_ch: type, length and payload with
// byte zero in the low bits and unused bytes zero. a bad crc drops the frame
// with no beat.
// the cfg port (cfg_we, cfg_index, cfg_wdata) sets the start and type codes;
// write it only while no frame is in flight.
// throughput: one byte per cycle while no finished frame waits on a stalled
// out_ch. a byte is captured in an input register, the parser and the
// byte-wide crc update then run on it, and a finished frame lands in the
// output register, which drives the result beat.
// a stalled out_ch holds its beat; bytes keep flowing in, and only a byte
// that could complete another frame waits in the input register.
// reset (arst_n low) returns the parser to the start-byte hunt, empties both
// registers and loads the default codes (aa, 55, 01, 02).
module crc_checked_frame_receiver #(
	parameter int MAX_PAYLOAD_BYTES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [crcfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crcfr_pkg::BYTE_W-1:0]    cfg_wdata,
	crcfr_in_if.sink                        in_ch,
	crcfr_out_if.source                     out_ch
);
	import crcfr_pkg::*;

	localparam int IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD_BYTES);
	// lengths clamped to the store depth
	localparam logic [LEN_W-1:0] SENSOR_LEN =
		(SENSOR_LEN_FULL > MAX_LEN) ? MAX_LEN : SENSOR_LEN_FULL;
	localparam logic [LEN_W-1:0] SYNC_LEN =
		(SYNC_LEN_FULL > MAX_LEN) ? MAX_LEN : SYNC_LEN_FULL;

	// configuration registers
	logic [BYTE_W-1:0] start_first_q;
	logic [BYTE_W-1:0] start_second_q;
	logic [BYTE_W-1:0] sensor_type_q;
	logic [BYTE_W-1:0] sync_type_q;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// parser state
	parse_stage_t      stage_q, stage_d;
	logic [BYTE_W-1:0] type_q, type_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  cnt_q, cnt_d;
	logic [CRC_W-1:0]  crc_q, crc_d;
	logic [BYTE_W-1:0] crc_lo_q, crc_lo_d;
	logic              crc_seen_q, crc_seen_d;
	logic [BYTE_W-1:0] store_q [MAX_PAYLOAD_BYTES];
	logic              store_we;

	// output register
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_type_q;
	logic [LEN_W-1:0]     out_len_q;
	logic [PAYLOAD_W-1:0] out_data_q;

	logic                 emit;
	logic                 emit_possible;
	logic                 advance;
	logic [PAYLOAD_W-1:0] packed_data;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_first_q  <= 8'd170;
			start_second_q <= 8'd85;
			sensor_type_q  <= 8'd1;
			sync_type_q    <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_FIRST:  start_first_q  <= cfg_wdata;
				REG_START_SECOND: start_second_q <= cfg_wdata;
				REG_SENSOR_TYPE:  sensor_type_q  <= cfg_wdata;
				REG_SYNC_TYPE:    sync_type_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// only the second crc byte can finish a frame; it waits while the
	// output register is still full
	assign emit_possible = (stage_q == STG_CRC) && crc_seen_q;
	assign advance = valid_s1 && !(emit_possible && out_valid_q && !out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid)
			byte_s1 <= in_ch.rx_byte;
	end

	// parser next state
	always_comb begin
		stage_d    = stage_q;
		type_d     = type_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		crc_d      = crc_q;
		crc_lo_d   = crc_lo_q;
		crc_seen_d = crc_seen_q;
		store_we   = 1'b0;
		emit       = 1'b0;

		case (stage_q)
			STG_HUNT_FIRST: begin
				if (byte_s1 == start_first_q)
					stage_d = STG_HUNT_SECOND;
			end
			STG_HUNT_SECOND: begin
				// second start byte is tested first
				if (byte_s1 == start_second_q) begin
					stage_d = STG_TYPE;
				end else if (byte_s1 != start_first_q) begin
					stage_d = STG_HUNT_FIRST;
					type_d = '0; len_d = '0; cnt_d = '0;
					crc_d = '0; crc_lo_d = '0; crc_seen_d = 1'b0;
				end
			end
			STG_TYPE: begin
				if (byte_s1 == sensor_type_q || byte_s1 == sync_type_q) begin
					stage_d  = STG_PAYLOAD;
					type_d   = byte_s1;
					len_d    = (byte_s1 == sensor_type_q) ? SENSOR_LEN : SYNC_LEN;
					cnt_d    = '0;
					crc_lo_d = '0;
					crc_d    = crc16_byte(CRC_INIT, byte_s1);
				end else begin
					stage_d = STG_HUNT_FIRST;
					type_d = '0; len_d = '0; cnt_d = '0;
					crc_d = '0; crc_lo_d = '0; crc_seen_d = 1'b0;
				end
			end
			STG_PAYLOAD: begin
				store_we = (cnt_q < MAX_LEN);
				cnt_d    = cnt_q + 4'd1;
				crc_d    = crc16_byte(crc_q, byte_s1);
				if (cnt_d >= len_q) begin
					crc_seen_d = 1'b0;
					stage_d    = STG_CRC;
				end
			end
			STG_CRC: begin
				if (!crc_seen_q) begin
					crc_lo_d   = byte_s1;
					crc_seen_d = 1'b1;
				end else begin
					emit    = ({byte_s1, crc_lo_q} == crc_q);
					stage_d = STG_HUNT_FIRST;
					type_d = '0; len_d = '0; cnt_d = '0;
					crc_d = '0; crc_lo_d = '0; crc_seen_d = 1'b0;
				end
			end
			default: begin
				stage_d = STG_HUNT_FIRST;
				type_d = '0; len_d = '0; cnt_d = '0;
				crc_d = '0; crc_lo_d = '0; crc_seen_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q    <= STG_HUNT_FIRST;
			type_q     <= '0;
			len_q      <= '0;
			cnt_q      <= '0;
			crc_q      <= '0;
			crc_lo_q   <= '0;
			crc_seen_q <= 1'b0;
		end else if (advance) begin
			stage_q    <= stage_d;
			type_q     <= type_d;
			len_q      <= len_d;
			cnt_q      <= cnt_d;
			crc_q      <= crc_d;
			crc_lo_q   <= crc_lo_d;
			crc_seen_q <= crc_seen_d;
		end
	end

	// payload store
	always_ff @(posedge clk) begin
		if (advance && store_we)
			store_q[cnt_q[IDX_W-1:0]] <= byte_s1;
	end

	// bytes past the frame length read as zero
	always_comb begin
		packed_data = '0;
		for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
			if (LEN_W'(i) < len_q)
				packed_data[8*i +: 8] = store_q[i];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_type_q <= type_q;
			out_len_q  <= len_q;
			out_data_q <= packed_data;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.frame_type     = out_type_q;
	assign out_ch.payload_length = out_len_q;
	assign out_ch.payload_data   = out_data_q;

endmodule

FILE: sim/tb_crc_checked_frame_receiver.sv
`timescale 1ns / 1ps

// drives framed byte streams into the receiver and checks every frame beat
// against an in-bench parser that tracks the same codes and state
module tb_crc_checked_frame_receiver;
	import crcfr_pkg::*;

	localparam int MAX_BYTES       = 8;
	localparam int BYTE_IDX_W      = $clog2(MAX_BYTES);
	localparam int RESET_CYCLES    = 11;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 4;
	localparam int TAIL_CYCLES     = 20;
	localparam int PHASE_ITEMS     = 250;
	localparam int PRESSURE_FRAMES = 6;
	localparam int REPORT_LIMIT    = 10;

	// one frame as it leaves on the output channel
	typedef struct packed {
		logic [BYTE_W-1:0]    ftype;
		logic [LEN_W-1:0]     len;
		logic [PAYLOAD_W-1:0] data;
	} frame_t;

	// shapes of byte sequences the sender can produce
	typedef enum logic [2:0] {
		FR_GOOD,
		FR_BAD_CRC,
		FR_UNKNOWN_TYPE,
		FR_BROKEN_START,
		FR_NOISE
	} frame_kind_t;

	// how the output side takes beats
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	typedef struct {
		frame_kind_t          kind;
		logic [BYTE_W-1:0]    ftype;
		logic [PAYLOAD_W-1:0] payload;
		bit                   extra_start;
		bit                   has_result;
		frame_t               typed;
	} directed_row_t;

	// directed frames under the reset codes (aa 55 01 02)
	// row 0: sync frame of zeros behind a repeated first start byte
	// row 1: unknown type ff, the hunt restarts with no beat
	// row 2: sensor frame of all ones
	directed_row_t directed_rows [3] = '{
		'{FR_GOOD, 8'h02, 64'h0, 1'b1, 1'b1, '{8'h02, 4'd2, 64'h0}},
		'{FR_UNKNOWN_TYPE, 8'hFF, 64'h0, 1'b0, 1'b0, '{8'h00, 4'd0, 64'h0}},
		'{FR_GOOD, 8'h01, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
			'{8'h01, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_wdata;

	crcfr_in_if  in_ch ();
	crcfr_out_if out_ch ();

	// mirror of the code registers, loaded with the reset defaults
	logic [BYTE_W-1:0] start_first_code  = 8'hAA;
	logic [BYTE_W-1:0] start_second_code = 8'h55;
	logic [BYTE_W-1:0] sensor_code       = 8'h01;
	logic [BYTE_W-1:0] sync_code         = 8'h02;

	// mirror of the parser
	parse_stage_t      rx_stage = STG_HUNT_FIRST;
	logic [BYTE_W-1:0] held_type = '0;
	logic [LEN_W-1:0]  frame_len = '0;
	logic [LEN_W-1:0]  bytes_taken = '0;
	logic [BYTE_W-1:0] payload_bytes [MAX_BYTES];
	logic [CRC_W-1:0]  crc_acc = '0;
	logic [CRC_W-1:0]  crc_rx = '0;
	logic              crc_low_seen = 1'b0;

	frame_t frames_due [$];
	frame_t last_predicted;
	int     frames_predicted = 0;
	int     mismatch_count = 0;

	// sender and receiver pacing
	rx_mode_t          rx_mode = RX_ALWAYS;
	int                hold_left = 0;
	bit                tx_steady = 1'b0;
	int                burst_left = 0;
	int                bytes_sent = 0;
	logic [BYTE_W-1:0] tx_bytes [$];

	crc_checked_frame_receiver #(
		.MAX_PAYLOAD_BYTES(MAX_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	// crc-16/ccitt, one bit per step, msb of the byte first
	function automatic logic [CRC_W-1:0] crc_ccitt_step(
		input logic [CRC_W-1:0]  crc,
		input logic [BYTE_W-1:0] b
	);
		logic [CRC_W-1:0] c;
		logic             fb;
		c = crc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = c[CRC_W-1] ^ b[i];
			c = {c[CRC_W-2:0], 1'b0};
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	// payload length announced by a type byte, zero for an unknown type
	// the sensor code is tested first, so it wins when both codes match
	function automatic logic [LEN_W-1:0] payload_len_for(input logic [BYTE_W-1:0] t);
		logic [LEN_W-1:0] n;
		n = '0;
		if (t == sensor_code)
			n = SENSOR_LEN_FULL;
		else if (t == sync_code)
			n = SYNC_LEN_FULL;
		if (n > MAX_BYTES)
			n = LEN_W'(MAX_BYTES);
		return n;
	endfunction

	// random byte that differs from all four given values
	function automatic logic [BYTE_W-1:0] pick_other(
		input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b,
		input logic [BYTE_W-1:0] c,
		input logic [BYTE_W-1:0] d
	);
		logic [BYTE_W-1:0] v;
		v = BYTE_W'($urandom);
		while (v == a || v == b || v == c || v == d)
			v = v + 8'd1;
		return v;
	endfunction

	// back to the start-byte hunt; the payload store keeps its bytes
	task automatic clear_parser();
		rx_stage = STG_HUNT_FIRST;
		held_type = '0;
		frame_len = '0;
		bytes_taken = '0;
		crc_acc = '0;
		crc_rx = '0;
		crc_low_seen = 1'b0;
	endtask

	// advance the mirrored parser by one accepted byte
	task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] n;
		frame_t           f;
		case (rx_stage)
			STG_HUNT_FIRST: begin
				if (b == start_first_code)
					rx_stage = STG_HUNT_SECOND;
			end
			STG_HUNT_SECOND: begin
				// second code tested first; a repeated first byte keeps the hunt armed
				if (b == start_second_code)
					rx_stage = STG_TYPE;
				else if (b != start_first_code)
					clear_parser();
			end
			STG_TYPE: begin
				n = payload_len_for(b);
				if (n == 0) begin
					clear_parser();
				end else begin
					held_type = b;
					frame_len = n;
					bytes_taken = '0;
					crc_rx = '0;
					crc_acc = crc_ccitt_step(CRC_INIT, b);
					rx_stage = STG_PAYLOAD;
				end
			end
			STG_PAYLOAD: begin
				if (bytes_taken < MAX_BYTES)
					payload_bytes[bytes_taken[BYTE_IDX_W-1:0]] = b;
				bytes_taken = bytes_taken + 1'b1;
				crc_acc = crc_ccitt_step(crc_acc, b);
				if (bytes_taken >= frame_len) begin
					crc_low_seen = 1'b0;
					rx_stage = STG_CRC;
				end
			end
			STG_CRC: begin
				// crc arrives low byte first
				if (!crc_low_seen) begin
					crc_rx = crc_rx | {8'h00, b};
					crc_low_seen = 1'b1;
				end else begin
					crc_rx = crc_rx | {b, 8'h00};
					if (crc_rx == crc_acc) begin
						f.ftype = held_type;
						f.len = frame_len;
						f.data = '0;
						for (int i = 0; i < MAX_BYTES; i++)
							if (i < frame_len)
								f.data[8*i +: 8] = payload_bytes[i];
						frames_due.push_back(f);
						frames_predicted++;
						last_predicted = f;
					end
					// a bad crc drops the frame without a beat
					clear_parser();
				end
			end
			default: begin
				clear_parser();
			end
		endcase
	endtask

	// everything is sampled at the rising edge: register writes, result
	// beats against the oldest expected frame, then accepted input bytes
	always @(posedge clk) begin : monitor
		frame_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_FIRST:  start_first_code = cfg_wdata;
					REG_START_SECOND: start_second_code = cfg_wdata;
					REG_SENSOR_TYPE:  sensor_code = cfg_wdata;
					REG_SYNC_TYPE:    sync_code = cfg_wdata;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (frames_due.size() == 0) begin
					note_failure($sformatf(
						"unexpected beat: type %h length %h data %h",
						out_ch.frame_type, out_ch.payload_length, out_ch.payload_data));
				end else begin
					want = frames_due.pop_front();
					if (out_ch.frame_type !== want.ftype)
						note_failure($sformatf("frame_type: expected %h, got %h",
							want.ftype, out_ch.frame_type));
					if (out_ch.payload_length !== want.len)
						note_failure($sformatf("payload_length: expected %h, got %h",
							want.len, out_ch.payload_length));
					if (out_ch.payload_data !== want.data)
						note_failure($sformatf("payload_data: expected %h, got %h",
							want.data, out_ch.payload_data));
				end
			end
			if (in_ch.valid && in_ch.ready)
				parse_rx_byte(in_ch.rx_byte);
		end
	end

	// output side: long hold-off when asked, else the current stall mode
	initial begin : receiver
		logic [15:0] stall_pattern;
		stall_pattern = 16'hB6ED;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_ALWAYS: out_ch.ready <= 1'b1;
					RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
					default: begin
						out_ch.ready <= stall_pattern[0];
						stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
					end
				endcase
			end
		end
	end

	// after an optional idle gap, offer one byte at a falling edge and hold it
	// until a beat is taken; returns at the falling edge after the beat
	task automatic drive_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (!tx_steady && burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 3);
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				in_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ch.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// build one byte sequence from the current codes and send it
	task automatic offer_frame(
		input frame_kind_t          kind,
		input logic [BYTE_W-1:0]    t,
		input logic [PAYLOAD_W-1:0] payload,
		input bit                   extra_start
	);
		logic [LEN_W-1:0]  n;
		logic [CRC_W-1:0]  crc;
		logic [BYTE_W-1:0] b;
		int                count;
		tx_bytes.delete();
		case (kind)
			FR_NOISE: begin
				count = $urandom_range(1, 4);
				repeat (count)
					tx_bytes.push_back(BYTE_W'($urandom));
			end
			FR_BROKEN_START: begin
				// first start byte, then something that is neither start code
				tx_bytes.push_back(start_first_code);
				tx_bytes.push_back(pick_other(start_first_code, start_second_code,
					start_first_code, start_second_code));
			end
			default: begin
				tx_bytes.push_back(start_first_code);
				if (extra_start)
					tx_bytes.push_back(start_first_code);
				tx_bytes.push_back(start_second_code);
				tx_bytes.push_back(t);
				if (kind != FR_UNKNOWN_TYPE) begin
					n = payload_len_for(t);
					crc = crc_ccitt_step(CRC_INIT, t);
					for (int i = 0; i < MAX_BYTES; i++) begin
						if (i < n) begin
							b = payload[8*i +: 8];
							tx_bytes.push_back(b);
							crc = crc_ccitt_step(crc, b);
						end
					end
					if (kind == FR_BAD_CRC)
						crc = crc ^ CRC_W'($urandom_range(1, 16'hFFFF));
					tx_bytes.push_back(crc[7:0]);
					tx_bytes.push_back(crc[15:8]);
				end
			end
		endcase
		foreach (tx_bytes[i])
			drive_byte(tx_bytes[i]);
	endtask

	// feed bytes that match no code until the parser is hunting again
	task automatic settle_parser();
		while (rx_stage != STG_HUNT_FIRST)
			drive_byte(pick_other(start_first_code, start_second_code, sensor_code, sync_code));
	endtask

	// stop offering and wait until every expected frame has left,
	// then let bytes still in the pipeline settle
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (frames_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(
		input logic [CFG_IDX_W-1:0] idx,
		input logic [BYTE_W-1:0]    value
	);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	// new codes only with the parser hunting and nothing in flight
	task automatic program_codes(
		input logic [BYTE_W-1:0] first_code,
		input logic [BYTE_W-1:0] second_code,
		input logic [BYTE_W-1:0] sensor_value,
		input logic [BYTE_W-1:0] sync_value
	);
		settle_parser();
		drain_results();
		write_reg(REG_START_FIRST, first_code);
		write_reg(REG_START_SECOND, second_code);
		write_reg(REG_SENSOR_TYPE, sensor_value);
		write_reg(REG_SYNC_TYPE, sync_value);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// mostly well-formed frames with random content, plus bad crcs,
	// unknown types, broken starts and loose noise
	task automatic run_random(input int n_items);
		int                   start_count;
		int                   pick;
		frame_kind_t          kind;
		logic [BYTE_W-1:0]    t;
		logic [PAYLOAD_W-1:0] payload;
		bit                   extra_start;
		start_count = bytes_sent;
		while (bytes_sent - start_count < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 62)
				kind = FR_GOOD;
			else if (pick < 74)
				kind = FR_BAD_CRC;
			else if (pick < 80)
				kind = FR_UNKNOWN_TYPE;
			else if (pick < 90)
				kind = FR_BROKEN_START;
			else
				kind = FR_NOISE;
			// noise can leave the parser mid-frame; usually resync first
			if ((kind == FR_GOOD || kind == FR_BAD_CRC) && rx_stage != STG_HUNT_FIRST
					&& $urandom_range(0, 3) != 0)
				settle_parser();
			if (kind == FR_UNKNOWN_TYPE)
				t = pick_other(sensor_code, sync_code, sensor_code, sync_code);
			else
				t = $urandom_range(0, 1) ? sensor_code : sync_code;
			case ($urandom_range(0, 9))
				0: payload = '0;
				1: payload = '1;
				default: payload = {$urandom, $urandom};
			endcase
			// a repeated first byte only makes sense with distinct start codes
			extra_start = (start_first_code != start_second_code) && ($urandom_range(0, 4) == 0);
			offer_frame(kind, t, payload, extra_start);
		end
	endtask

	initial begin : stimulus
		int seen_count;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START_FIRST;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.rx_byte = '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed frames: typed rows are also held against the mirrored parser
		rx_mode = RX_RANDOM;
		foreach (directed_rows[i]) begin
			seen_count = frames_predicted;
			offer_frame(directed_rows[i].kind, directed_rows[i].ftype,
				directed_rows[i].payload, directed_rows[i].extra_start);
			if (directed_rows[i].has_result) begin
				if (frames_predicted != seen_count + 1
						|| last_predicted !== directed_rows[i].typed)
					note_failure($sformatf("directed row %0d: expected frame %h, parser gave %h",
						i, directed_rows[i].typed, last_predicted));
			end else if (frames_predicted != seen_count) begin
				note_failure($sformatf("directed row %0d: expected no frame", i));
			end
		end
		run_random(PHASE_ITEMS);

		// extreme codes, both ways round
		program_codes(8'h00, 8'hFF, 8'hFF, 8'h00);
		rx_mode = RX_PATTERN;
		run_random(PHASE_ITEMS);

		// stretch with no idling on either side
		program_codes(8'hFF, 8'h00, 8'h00, 8'hFF);
		rx_mode = RX_ALWAYS;
		tx_steady = 1'b1;
		run_random(PHASE_ITEMS);
		tx_steady = 1'b0;

		// equal start codes and equal type codes (sensor length wins)
		program_codes(8'h7E, 8'h7E, 8'h33, 8'h33);
		rx_mode = RX_RANDOM;
		run_random(PHASE_ITEMS);

		// long output hold-off while full frames keep coming, so the
		// block backs up into its input; then wait for every frame
		program_codes(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
			BYTE_W'($urandom));
		rx_mode = RX_ALWAYS;
		hold_left = HOLD_OFF_CYCLES;
		tx_steady = 1'b1;
		repeat (PRESSURE_FRAMES)
			offer_frame(FR_GOOD, sensor_code, {$urandom, $urandom}, 1'b0);
		tx_steady = 1'b0;
		drain_results();
		rx_mode = RX_PATTERN;
		run_random(PHASE_ITEMS);

		program_codes(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
			BYTE_W'($urandom));
		rx_mode = RX_RANDOM;
		run_random(PHASE_ITEMS);

		// back to the reset codes by explicit writes
		program_codes(8'hAA, 8'h55, 8'h01, 8'h02);
		run_random(PHASE_ITEMS);

		drain_results();
		repeat (TAIL_CYCLES)
			@(negedge clk);
		if (mismatch_count == 0 && frames_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
